[sv/lcd_pkg.sv]
// Shared constants for the load change detector: register indexes,
// operation codes, field widths and reset values.
// No dependencies.
`default_nettype none

package lcd_pkg;

   localparam int DEFAULT_WINDOW_DEPTH = 8;

   localparam int FORCE_W   = 16;
   localparam int WEIGHT_W  = 16;
   localparam int CONFIRM_W = 16;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 16;
   localparam int REQ_DATA_W = 16;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_DELTA  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_CONFIRM_COUNT = 1'b1;

   localparam logic OP_SAMPLE  = 1'b0;
   localparam logic OP_RESTART = 1'b1;

   localparam logic signed [WEIGHT_W-1:0] WEIGHT_RESET  = '0;
   localparam logic [CONFIRM_W-1:0]       CONFIRM_RESET = 16'd1;

endpackage

`default_nettype wire

[sv/load_change_detector.sv]
// Load change detector: sliding window sum over force samples, baseline capture
// and confirmed threshold crossing. Depends on lcd_pkg.
//
// Each accepted req beat has its rsp beat in the output register in the next cycle.
// Throughput: one beat per cycle; req_tready drops only while a result is held
// in the output register and rsp_tready is low.
// Reset (synchronous): clears pointer, sums, baseline and confirm state, loads
// the registers with their reset values. The sample shift line is not cleared.
`default_nettype none

module load_change_detector #(
   parameter int WINDOW_DEPTH = lcd_pkg::DEFAULT_WINDOW_DEPTH
) (
   input  wire                               clock,
   input  wire                               reset,
   // req_tdata: [15:0] force_sample
   input  wire                               req_tvalid,
   output logic                              req_tready,
   input  wire  [lcd_pkg::REQ_DATA_W-1:0]    req_tdata,
   // req_tuser: [0] op, [1] stop_trigger
   input  wire  [lcd_pkg::REQ_USER_W-1:0]    req_tuser,
   // rsp_tdata: [0] done_res, [1] baseline_valid, [17:2] average_force, rest zero
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   output logic [lcd_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  wire                               csr_we,
   input  wire  [lcd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire  [lcd_pkg::CSR_DAT_W-1:0]     csr_wdata
);
   import lcd_pkg::*;

   localparam int SLOT_W = $clog2(WINDOW_DEPTH);
   localparam int SUM_W  = FORCE_W + $clog2(WINDOW_DEPTH);
   localparam int DIFF_W = SUM_W + 1;
   localparam int SHIFT  = $clog2(WINDOW_DEPTH + 1) - 1;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_DEPTH - 1);

   // configuration
   logic signed [WEIGHT_W-1:0]  weight_ff;
   logic [CONFIRM_W-1:0]        confirm_ff;

   // detector state
   logic [SLOT_W-1:0]           slot_ff, slot_in;
   logic signed [SUM_W-1:0]     window_sum_ff, window_sum_in;
   logic signed [SUM_W-1:0]     baseline_ff, baseline_in;
   logic                        have_baseline_ff, have_baseline_in;
   logic                        confirming_ff, confirming_in;
   logic [CONFIRM_W-1:0]        lag_ff, lag_in;
   logic signed [FORCE_W-1:0]   taps_ff [WINDOW_DEPTH];
   logic                        shift_en;

   // output register
   logic                        rsp_valid_ff;
   logic [RSP_DATA_W-1:0]       rsp_data_ff, rsp_data_in;

   logic                        req_fire;
   logic                        beat_op;
   logic                        beat_stop;
   logic signed [FORCE_W-1:0]   beat_sample;
   logic signed [SUM_W-1:0]     sum_step;
   logic signed [DIFF_W-1:0]    diff;
   logic signed [DIFF_W-1:0]    limit;
   logic                        hit;
   logic [CONFIRM_W-1:0]        lag_base;
   logic [CONFIRM_W-1:0]        lag_dec;
   logic                        done;
   logic signed [SUM_W-1:0]     avg_full;

   assign req_tready  = !rsp_valid_ff || rsp_tready;
   assign req_fire    = req_tvalid && req_tready;
   assign beat_op     = req_tuser[0];
   assign beat_stop   = req_tuser[1];
   assign beat_sample = $signed(req_tdata[FORCE_W-1:0]);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff  <= WEIGHT_RESET;
         confirm_ff <= CONFIRM_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WEIGHT_DELTA:  weight_ff  <= $signed(csr_wdata[WEIGHT_W-1:0]);
            CSR_CONFIRM_COUNT: confirm_ff <= csr_wdata[CONFIRM_W-1:0];
            default: ;
         endcase
      end
   end

   // Window arithmetic: drop the oldest tap once the window is full.
   assign sum_step = have_baseline_ff
                   ? window_sum_ff + SUM_W'(beat_sample) - SUM_W'(taps_ff[WINDOW_DEPTH-1])
                   : window_sum_ff + SUM_W'(beat_sample);
   assign diff  = DIFF_W'(sum_step) - DIFF_W'(baseline_ff);
   assign limit = DIFF_W'(weight_ff) * $signed(DIFF_W'(WINDOW_DEPTH));
   assign hit   = ((weight_ff > 0) && (diff > limit)) ||
                  ((weight_ff < 0) && (diff < limit));

   // Reload the countdown at the start of a confirming run; saturate at zero.
   assign lag_base = confirming_ff ? lag_ff : confirm_ff;
   assign lag_dec  = (lag_base == '0) ? '0 : lag_base - 1'b1;

   always_comb begin
      slot_in          = slot_ff;
      window_sum_in    = window_sum_ff;
      baseline_in      = baseline_ff;
      have_baseline_in = have_baseline_ff;
      confirming_in    = confirming_ff;
      lag_in           = lag_ff;
      shift_en         = 1'b0;
      done             = 1'b0;
      if (beat_op == OP_RESTART) begin
         slot_in          = '0;
         window_sum_in    = '0;
         baseline_in      = '0;
         have_baseline_in = 1'b0;
         confirming_in    = 1'b0;
         lag_in           = confirm_ff;
      end else if (beat_stop) begin
         done = 1'b1;
      end else begin
         shift_en      = 1'b1;
         window_sum_in = sum_step;
         slot_in       = (slot_ff == LAST_SLOT) ? '0 : slot_ff + 1'b1;
         if (!have_baseline_ff) begin
            if (slot_ff == LAST_SLOT) begin
               have_baseline_in = 1'b1;
               baseline_in      = sum_step;
            end
         end else if (hit) begin
            confirming_in = 1'b1;
            lag_in        = lag_dec;
            done          = (lag_dec == '0);
         end else begin
            confirming_in = 1'b0;
         end
      end
      avg_full    = window_sum_in >>> SHIFT;
      rsp_data_in = {(RSP_DATA_W - FORCE_W - 2)'(0), avg_full[FORCE_W-1:0],
                     have_baseline_in, done};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff          <= '0;
         window_sum_ff    <= '0;
         baseline_ff      <= '0;
         have_baseline_ff <= 1'b0;
         confirming_ff    <= 1'b0;
         lag_ff           <= CONFIRM_RESET;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (req_fire) begin
            slot_ff          <= slot_in;
            window_sum_ff    <= window_sum_in;
            baseline_ff      <= baseline_in;
            have_baseline_ff <= have_baseline_in;
            confirming_ff    <= confirming_in;
            lag_ff           <= lag_in;
            rsp_valid_ff     <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Sample shift line and result payload: no reset needed.
   always_ff @(posedge clock) begin
      if (req_fire && shift_en) begin
         taps_ff[0] <= beat_sample;
         for (int i = 1; i < WINDOW_DEPTH; i++) begin
            taps_ff[i] <= taps_ff[i-1];
         end
      end
      if (req_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

`ifndef ASSERT_OFF
   a_restart_clears : assert property (@(posedge clock) disable iff (reset)
      (req_fire && beat_op == OP_RESTART) |=> (!have_baseline_ff && window_sum_ff == '0))
      else $error("restart beat did not clear baseline and window sum");

   a_confirm_needs_baseline : assert property (@(posedge clock) disable iff (reset)
      confirming_ff |-> have_baseline_ff)
      else $error("confirming without a captured baseline");

   a_stop_holds_sum : assert property (@(posedge clock) disable iff (reset)
      (req_fire && beat_op == OP_SAMPLE && beat_stop) |=> $stable(window_sum_ff))
      else $error("stop beat changed the window sum");
`endif

endmodule

`default_nettype wire

[bench/tb_load_change_detector.sv]
`timescale 1ns / 1ps
// Testbench for load_change_detector: directed table, then random sample streams with
// restarts and stop triggers, checked beat by beat against fixed table values or
// an in-bench detector copy. Depends on lcd_pkg and load_change_detector.

module tb_load_change_detector;
   import lcd_pkg::*;

   localparam int DEPTH       = DEFAULT_WINDOW_DEPTH;
   localparam int SHIFT       = $clog2(DEPTH + 1) - 1;   // floor(log2(DEPTH))
   localparam int PHASES      = 10;
   localparam int PHASE_ITEMS = 170;
   localparam int HOLD_CYCLES = 64;
   localparam int STALL_LIMIT = 1000;
   localparam int DIR_N       = 25;

   typedef struct packed {
      logic        done;
      logic        base_ok;
      logic [15:0] avg;
   } load_status_type;

   typedef struct {
      logic            op;
      logic [15:0]     smp;
      logic            trig;
      bit              fixed;
      load_status_type want;
   } dir_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DAT_W-1:0]  csr_wdata = '0;

   load_change_detector u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // detector copy: ring, running sums, confirm state and register values
   logic signed [15:0] win_ring [DEPTH];
   int  slot = 0;
   int  run_sum = 0;
   int  base_sum = 0;
   bit  have_base = 1'b0;
   bit  in_confirm = 1'b0;
   int  lag = 1;
   int  thr = 0;
   int  need = 1;

   load_status_type pending_status [$];
   load_status_type seen_want;
   dir_row_type     dir_rows [DIR_N];
   int              mismatches = 0;
   int              tx_idle_pct = 0;
   int              rx_idle_pct = 0;
   bit              pressure_arm = 1'b0;
   bit              pressure_seen = 1'b0;
   int              hold_left = 0;
   int              quiet_cycles = 0;

   function automatic load_status_type next_load_status(logic op, logic signed [15:0] smp,
                                                        logic trig);
      load_status_type r;
      int              diff;
      int              lim;
      bit              hit;
      r.done = 1'b0;
      if (op == OP_RESTART) begin
         slot = 0;
         run_sum = 0;
         base_sum = 0;
         have_base = 1'b0;
         in_confirm = 1'b0;
         lag = need;
      end else if (trig) begin
         r.done = 1'b1;
      end else begin
         if (have_base) begin
            run_sum = run_sum - win_ring[slot] + smp;
         end else begin
            run_sum = run_sum + smp;
         end
         win_ring[slot] = smp;
         slot = (slot == DEPTH - 1) ? 0 : slot + 1;
         if (!have_base) begin
            // first full window after a restart becomes the baseline
            if (slot == 0) begin
               have_base = 1'b1;
               base_sum = run_sum;
            end
         end else begin
            diff = run_sum - base_sum;
            lim = thr * DEPTH;
            hit = (thr > 0 && diff > lim) || (thr < 0 && diff < lim);
            if (hit) begin
               if (!in_confirm) begin
                  lag = need;
               end
               in_confirm = 1'b1;
               if (lag > 0) begin
                  lag = lag - 1;
               end
               if (lag == 0) begin
                  r.done = 1'b1;
               end
            end else begin
               in_confirm = 1'b0;
            end
         end
      end
      r.base_ok = have_base;
      r.avg = 16'(run_sum >>> SHIFT);
      return r;
   endfunction

   task automatic send_beat(logic op, logic [15:0] smp, logic trig, bit fixed,
                            load_status_type want);
      load_status_type st;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= smp;
      req_tuser <= {trig, op};
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      st = next_load_status(op, smp, trig);
      pending_status.push_back(fixed ? want : st);
   endtask

   task automatic write_regs(logic [15:0] weight, logic [15:0] confirm);
      csr_we <= 1'b1;
      csr_index <= CSR_WEIGHT_DELTA;
      csr_wdata <= weight;
      @(posedge clock);
      csr_index <= CSR_CONFIRM_COUNT;
      csr_wdata <= confirm;
      @(posedge clock);
      csr_we <= 1'b0;
      thr = $signed(weight);
      need = confirm;
   endtask

   // drop valid, wait for every pending status beat, then let the pipe settle
   task automatic settle_idle();
      req_tvalid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (pressure_arm && !pressure_seen) begin
         // long back-pressure so the output register fills and req_tready drops
         pressure_seen <= 1'b1;
         hold_left <= HOLD_CYCLES - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         if (pending_status.size() == 0) begin
            if (mismatches < 10) begin
               $display("status beat with nothing pending: tdata=%h", rsp_tdata);
            end
            mismatches <= mismatches + 1;
         end else begin
            seen_want = pending_status.pop_front();
            if (rsp_tdata[0] !== seen_want.done || rsp_tdata[1] !== seen_want.base_ok ||
                rsp_tdata[17:2] !== seen_want.avg || rsp_tdata[23:18] !== 6'd0) begin
               if (mismatches < 10) begin
                  $display("status mismatch: expected %0b %0b %0d, actual %0b %0b %0d, pad %h",
                           seen_want.done, seen_want.base_ok, $signed(seen_want.avg),
                           rsp_tdata[0], rsp_tdata[1], $signed(rsp_tdata[17:2]),
                           rsp_tdata[23:18]);
               end
               mismatches <= mismatches + 1;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int          ph;
      int          n;
      int          roll;
      int          level;
      int          v;
      logic        op;
      logic        trig;
      logic [15:0] smp;
      logic [15:0] phase_weight [PHASES];
      logic [15:0] phase_confirm [PHASES];

      phase_weight  = '{16'h0000, 16'h7FFF, 16'h8000, 16'h003C, 16'hFFD3,
                        16'h0001, 16'hFFFF, 16'h012C, 16'h0000, 16'h0000};
      phase_confirm = '{16'd1, 16'hFFFF, 16'd0, 16'd3, 16'd1,
                        16'd2, 16'd0, 16'd7, 16'd0, 16'd0};
      phase_weight[8]  = 16'($urandom_range(65535));
      phase_weight[9]  = 16'($urandom_range(65535));
      phase_confirm[8] = 16'($urandom_range(8));
      phase_confirm[9] = 16'($urandom_range(8));

      // threshold -32768, confirm 2: full-scale up fill, then full-scale down crossing
      dir_rows = '{
         '{OP_SAMPLE,  16'h7FFF, 1'b1, 1'b1, '{1'b1, 1'b0, 16'h0000}},
         '{OP_RESTART, 16'h8000, 1'b1, 1'b1, '{1'b0, 1'b0, 16'h0000}},
         '{OP_SAMPLE,  16'h7FFF, 1'b0, 1'b0, '0},
         '{OP_SAMPLE,  16'h7FFF, 1'b0, 1'b0, '0},
         '{OP_SAMPLE,  16'h7FFF, 1'b0, 1'b0, '0},
         '{OP_SAMPLE,  16'h7FFF, 1'b0, 1'b0, '0},
         '{OP_SAMPLE,  16'h7FFF, 1'b0, 1'b0, '0},
         '{OP_SAMPLE,  16'h7FFF, 1'b0, 1'b0, '0},
         '{OP_SAMPLE,  16'h7FFF, 1'b0, 1'b0, '0},
         '{OP_SAMPLE,  16'h7FFF, 1'b0, 1'b1, '{1'b0, 1'b1, 16'h7FFF}},
         '{OP_SAMPLE,  16'h8000, 1'b0, 1'b0, '0},
         '{OP_SAMPLE,  16'h8000, 1'b0, 1'b0, '0},
         '{OP_SAMPLE,  16'h8000, 1'b0, 1'b0, '0},
         '{OP_SAMPLE,  16'h8000, 1'b0, 1'b0, '0},
         '{OP_SAMPLE,  16'h8000, 1'b0, 1'b0, '0},
         '{OP_SAMPLE,  16'h8000, 1'b0, 1'b0, '0},
         '{OP_SAMPLE,  16'h8000, 1'b0, 1'b0, '0},
         '{OP_SAMPLE,  16'h8000, 1'b0, 1'b1, '{1'b1, 1'b1, 16'h8000}},
         '{OP_SAMPLE,  16'h0000, 1'b1, 1'b1, '{1'b1, 1'b1, 16'h8000}},
         '{OP_RESTART, 16'h0000, 1'b0, 1'b1, '{1'b0, 1'b0, 16'h0000}},
         '{OP_SAMPLE,  16'h0000, 1'b0, 1'b0, '0},
         '{OP_SAMPLE,  16'hFFFF, 1'b0, 1'b0, '0},
         '{OP_SAMPLE,  16'h0001, 1'b0, 1'b0, '0},
         '{OP_SAMPLE,  16'h5555, 1'b0, 1'b0, '0},
         '{OP_SAMPLE,  16'hAAAA, 1'b0, 1'b0, '0}
      };

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      tx_idle_pct = 16;
      rx_idle_pct <= 74;
      write_regs(16'h8000, 16'd2);
      for (n = 0; n < DIR_N; n++) begin
         send_beat(dir_rows[n].op, dir_rows[n].smp, dir_rows[n].trig, dir_rows[n].fixed,
                   dir_rows[n].want);
      end

      level = 0;
      for (ph = 0; ph < PHASES; ph++) begin
         settle_idle();
         write_regs(phase_weight[ph], phase_confirm[ph]);
         if (ph == 4) begin
            tx_idle_pct = 74;
            rx_idle_pct <= 16;
         end else if (ph == 7) begin
            tx_idle_pct = 0;
            rx_idle_pct <= 0;
            pressure_arm <= 1'b1;
         end
         for (n = 0; n < PHASE_ITEMS; n++) begin
            roll = $urandom_range(99);
            op = OP_SAMPLE;
            trig = 1'b0;
            smp = 16'($urandom_range(65535));
            if (roll < 2) begin
               op = OP_RESTART;
               trig = 1'($urandom_range(1));
            end else if (roll < 5) begin
               trig = 1'b1;
            end else begin
               // hover around a level that jumps now and then; some raw noise
               roll = $urandom_range(99);
               if (roll < 5) begin
                  level = $signed(16'($urandom_range(65535)));
               end
               if (roll < 95) begin
                  v = level + int'($urandom_range(128)) - 64;
                  if (v > 32767) v = 32767;
                  if (v < -32768) v = -32768;
                  smp = 16'(v);
               end
            end
            send_beat(op, smp, trig, 1'b0, '0);
         end
      end

      settle_idle();
      repeat (4) @(posedge clock);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
